// ===== rtl/core/xcpf_pkg.sv =====
// shared constants, codes and types of the xor checked packet framer
package xcpf_pkg;

	// frame constants
	localparam logic [7:0] PREAMBLE_0     = 8'hA0;
	localparam logic [7:0] PREAMBLE_1     = 8'hA1;
	localparam logic [7:0] PREAMBLE_2     = 8'hA2;
	localparam logic [7:0] END_MARKER     = 8'hAA;
	localparam logic [7:0] FRAME_OVERHEAD = 8'd12;

	// default depth of the command queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// configuration register indexes
	localparam int CFG_INDEX_W = 8;
	localparam logic [CFG_INDEX_W-1:0] REG_SENDER_ID   = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RECEIVER_ID = 8'd1;

	// position of a byte inside the frame
	typedef logic [3:0] byte_idx_t;
	localparam byte_idx_t IDX_PRE0   = 4'd0;
	localparam byte_idx_t IDX_PRE1   = 4'd1;
	localparam byte_idx_t IDX_PRE2   = 4'd2;
	localparam byte_idx_t IDX_SENDER = 4'd3;
	localparam byte_idx_t IDX_TASK   = 4'd4;
	localparam byte_idx_t IDX_SIZE   = 4'd5;
	localparam byte_idx_t IDX_RCV0   = 4'd6;
	localparam byte_idx_t IDX_RCV1   = 4'd7;
	localparam byte_idx_t IDX_RCV2   = 4'd8;
	localparam byte_idx_t IDX_DATA   = 4'd9;
	localparam byte_idx_t IDX_END    = 4'd10;
	localparam byte_idx_t IDX_HCHECK = 4'd11;
	localparam byte_idx_t IDX_FINAL  = 4'd12;

	// one classified input word, everything the back end needs to emit it
	typedef struct packed {
		logic        first;
		logic        last;
		logic [7:0]  data;
		logic [7:0]  task_code;
		logic [7:0]  size;
		logic [7:0]  sender;
		logic [23:0] receiver;
		logic [7:0]  header_check;
		logic [7:0]  final_check;
	} frame_cmd_t;

	// queue status seen by front and back
	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

endpackage

// ===== rtl/core/xcpf_if.sv =====
// valid/ready channel interfaces of the framer

// input word channel
interface xcpf_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic [7:0] task_code;
	logic [7:0] payload_length;
	modport source(output valid, output payload_byte, output task_code,
		output payload_length, input ready);
	modport sink(input valid, input payload_byte, input task_code,
		input payload_length, output ready);
endinterface

// output byte channel
interface xcpf_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_end;
	modport source(output valid, output frame_byte, output frame_end, input ready);
	modport sink(input valid, input frame_byte, input frame_end, output ready);
endinterface

// register write channel
interface xcpf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [xcpf_pkg::CFG_INDEX_W-1:0] reg_index;
	logic [23:0]                    wdata;
	modport source(output valid, output reg_index, output wdata, input ready);
	modport sink(input valid, input reg_index, input wdata, output ready);
endinterface

// ===== rtl/core/xcpf_front.sv =====
// front end: accepts input words, tracks packet state and builds commands
module xcpf_front (
	input  logic                    clk,
	input  logic                    arst_n,
	xcpf_item_if.sink               item,
	input  logic [7:0]              sender_id,
	input  logic [23:0]             receiver_id,
	input  xcpf_pkg::queue_status_t qstat,
	output logic                    push,
	output xcpf_pkg::frame_cmd_t    cmd
);

	logic [7:0] count_q;
	logic [7:0] len_q;
	logic [7:0] hcheck_q;
	logic [7:0] run_q;

	logic       idle;
	logic       take;
	logic       drop;
	logic       last;
	logic [7:0] size;
	logic [7:0] hcheck_first;
	logic [7:0] count_nx;
	logic [7:0] len_cur;
	logic [7:0] hcheck_cur;
	logic [7:0] run_cur;

	assign item.ready = !qstat.full;

	// classify the word and compute the checks
	always_comb begin
		idle         = (count_q == 8'd0);
		take         = item.valid && item.ready;
		drop         = idle && (item.payload_length == 8'd0);
		size         = item.payload_length + xcpf_pkg::FRAME_OVERHEAD;
		hcheck_first = sender_id ^ item.task_code ^ size ^ receiver_id[23:16]
			^ receiver_id[15:8] ^ receiver_id[7:0];
		count_nx     = count_q + 8'd1;
		len_cur      = idle ? item.payload_length : len_q;
		hcheck_cur   = idle ? hcheck_first : hcheck_q;
		run_cur      = (idle ? hcheck_first : run_q) ^ item.payload_byte;
		last         = (count_nx >= len_cur);
		push         = take && !drop;

		cmd.first        = idle;
		cmd.last         = last;
		cmd.data         = item.payload_byte;
		cmd.task_code    = item.task_code;
		cmd.size         = size;
		cmd.sender       = sender_id;
		cmd.receiver     = receiver_id;
		cmd.header_check = hcheck_cur;
		cmd.final_check  = run_cur ^ xcpf_pkg::END_MARKER ^ hcheck_cur;
	end

	// packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 8'd0;
			len_q    <= 8'd0;
			hcheck_q <= 8'd0;
			run_q    <= 8'd0;
		end else if (push) begin
			if (last) begin
				count_q  <= 8'd0;
				len_q    <= 8'd0;
				hcheck_q <= 8'd0;
				run_q    <= 8'd0;
			end else begin
				count_q  <= count_nx;
				len_q    <= len_cur;
				hcheck_q <= hcheck_cur;
				run_q    <= run_cur;
			end
		end
	end

	// inside a packet the count stays below the latched length
	a_count_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != 8'd0) |-> (count_q < len_q))
		else $error("payload count reached latched length inside a packet");

endmodule

// ===== rtl/core/xcpf_queue.sv =====
// short command queue between front and back
module xcpf_queue #(
	parameter int DEPTH = xcpf_pkg::QUEUE_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  xcpf_pkg::frame_cmd_t    wr_cmd,
	input  logic                    pop,
	output xcpf_pkg::frame_cmd_t    head,
	output xcpf_pkg::queue_status_t qstat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	xcpf_pkg::frame_cmd_t mem_q [DEPTH];
	logic [PTR_W-1:0]     wr_q;
	logic [PTR_W-1:0]     rd_q;
	logic [CNT_W-1:0]     cnt_q;

	assign qstat.empty = (cnt_q == '0);
	assign qstat.full  = (cnt_q == CNT_W'(DEPTH));
	assign head        = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// no write into a full queue, no read from an empty one
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qstat.full))
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && qstat.empty))
		else $error("command queue underflow");

endmodule

// ===== rtl/core/xcpf_back.sv =====
// back end: expands each command into frame bytes behind an output register
module xcpf_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  xcpf_pkg::frame_cmd_t    head,
	input  xcpf_pkg::queue_status_t qstat,
	output logic                    pop,
	xcpf_frame_if.source            frame
);

	xcpf_pkg::frame_cmd_t cmd_q;
	logic                 active_q;
	xcpf_pkg::byte_idx_t  idx_q;
	logic                 valid_q;
	logic [7:0]           byte_q;
	logic                 end_q;

	xcpf_pkg::frame_cmd_t cur;
	xcpf_pkg::byte_idx_t  idx;
	xcpf_pkg::byte_idx_t  end_idx;
	logic                 avail;
	logic                 out_free;
	logic                 emit;
	logic                 done;
	logic [7:0]           next_byte;

	assign frame.valid      = valid_q;
	assign frame.frame_byte = byte_q;
	assign frame.frame_end  = end_q;

	// pick the command and byte position to emit
	always_comb begin
		cur      = active_q ? cmd_q : head;
		idx      = active_q ? idx_q
			: (head.first ? xcpf_pkg::IDX_PRE0 : xcpf_pkg::IDX_DATA);
		end_idx  = cur.last ? xcpf_pkg::IDX_FINAL : xcpf_pkg::IDX_DATA;
		avail    = active_q || !qstat.empty;
		out_free = !valid_q || frame.ready;
		emit     = avail && out_free;
		done     = (idx == end_idx);
		pop      = emit && !active_q;
	end

	// byte select
	always_comb begin
		case (idx)
			xcpf_pkg::IDX_PRE0:   next_byte = xcpf_pkg::PREAMBLE_0;
			xcpf_pkg::IDX_PRE1:   next_byte = xcpf_pkg::PREAMBLE_1;
			xcpf_pkg::IDX_PRE2:   next_byte = xcpf_pkg::PREAMBLE_2;
			xcpf_pkg::IDX_SENDER: next_byte = cur.sender;
			xcpf_pkg::IDX_TASK:   next_byte = cur.task_code;
			xcpf_pkg::IDX_SIZE:   next_byte = cur.size;
			xcpf_pkg::IDX_RCV0:   next_byte = cur.receiver[23:16];
			xcpf_pkg::IDX_RCV1:   next_byte = cur.receiver[15:8];
			xcpf_pkg::IDX_RCV2:   next_byte = cur.receiver[7:0];
			xcpf_pkg::IDX_DATA:   next_byte = cur.data;
			xcpf_pkg::IDX_END:    next_byte = xcpf_pkg::END_MARKER;
			xcpf_pkg::IDX_HCHECK: next_byte = cur.header_check;
			xcpf_pkg::IDX_FINAL:  next_byte = cur.final_check;
			default:              next_byte = 8'h00;
		endcase
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= xcpf_pkg::IDX_PRE0;
			valid_q  <= 1'b0;
		end else begin
			if (emit) begin
				valid_q <= 1'b1;
				if (done) begin
					active_q <= 1'b0;
				end else begin
					active_q <= 1'b1;
					idx_q    <= idx + 4'd1;
				end
			end else if (frame.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// held command and output word
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		if (emit) begin
			byte_q <= next_byte;
			end_q  <= (idx == xcpf_pkg::IDX_FINAL);
		end
	end

	// the final check only goes out for a command that closes a packet
	a_final_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && (idx == xcpf_pkg::IDX_FINAL)) |-> cur.last)
		else $error("final check emitted for a command that is not last");

endmodule

// ===== rtl/core/xor_checked_packet_framer.sv =====
// top level of the xor checked packet framer
//
// item channel: one payload word per transfer. On the first word of a packet
// payload_length is latched and task_code goes into the header; a first word
// of length zero is dropped. frame channel: one frame byte per transfer,
// frame_end marks the final check byte. cfg channel: reg_index 0 writes
// sender_id, 1 writes receiver_id; it is always ready and other indexes are
// ignored. The first byte caused by a word passes the command queue and the
// output register before it shows on frame. Throughput: while frame.ready is
// high the back end sends one byte per cycle; a first word makes 10 bytes, a
// middle word 1, a last word 4, a one-word packet 13, so middle words are
// taken one per cycle. The front end takes a word whenever the command queue
// between the two halves has room. The output register holds its byte while
// frame.ready is low; the queue then fills and item.ready drops. Reset clears
// packet state, the queue, the output valid and both configuration registers.
module xor_checked_packet_framer #(
	parameter int QUEUE_DEPTH = xcpf_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	xcpf_item_if.sink    item,
	xcpf_frame_if.source frame,
	xcpf_cfg_if.sink     cfg
);

	logic [7:0]              sender_q;
	logic [23:0]             receiver_q;
	logic                    push;
	logic                    pop;
	xcpf_pkg::frame_cmd_t    wr_cmd;
	xcpf_pkg::frame_cmd_t    head;
	xcpf_pkg::queue_status_t qstat;

	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sender_q   <= 8'd0;
			receiver_q <= 24'd0;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				xcpf_pkg::REG_SENDER_ID:   sender_q   <= cfg.wdata[7:0];
				xcpf_pkg::REG_RECEIVER_ID: receiver_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	// front end
	xcpf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.sender_id   (sender_q),
		.receiver_id (receiver_q),
		.qstat       (qstat),
		.push        (push),
		.cmd         (wr_cmd)
	);

	// command queue
	xcpf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	// back end
	xcpf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.frame  (frame)
	);

endmodule
